FILE: hw/rtl/integer_to_ascii_formatter_top_macros.svh
// Assertion macros for the integer to ASCII formatter.
// Included by the top level; needs nothing else.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define I2A_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define I2A_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/i2a_pkg.sv
// Shared constants, codes and helpers of the integer to ASCII formatter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

  // Buffer sizing
  localparam int BUF_CHARS  = 64;
  localparam int MAX_OUT    = 64;
  localparam int FILL_LIMIT = (BUF_CHARS < MAX_OUT) ? BUF_CHARS : MAX_OUT;
  localparam int ADDR_W     = $clog2(FILL_LIMIT);
  localparam int CNT_W      = 7;

  // Operand sizing
  localparam int VALUE_BITS = 64;
  localparam int CONV_W     = $clog2(VALUE_BITS + 1);
  // decimal digits needed for VALUE_BITS bits (log10(2) ~ 0.30103)
  localparam int BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DSRC_W     = 4 * BCD_DIGITS;
  localparam int PAD_W      = 8;

  // Payload widths of the channels
  localparam int IN_VALUE_W = 64;
  localparam int FLAGS_W    = 6;
  localparam int PADIN_W    = 6;
  localparam int CHAR_W     = 8;

  // Radix codes
  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  // Format flag bit positions
  localparam int FLAG_ZERO  = 0;
  localparam int FLAG_ALT   = 1;
  localparam int FLAG_LEFT  = 2;
  localparam int FLAG_SPC   = 3;
  localparam int FLAG_PLUS  = 4;
  localparam int FLAG_PREC  = 5;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_B     = 8'h62;

  // Digit value to lower-case ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {4'h0, d};
    if (d < 4'd10) begin
      digit_char = CH_ZERO + dx;
    end else begin
      digit_char = 8'h57 + dx;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/i2a_if.sv
// Valid/ready channel interfaces of the integer to ASCII formatter.
// Depends on i2a_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

// Input word: one operand and its format
interface i2a_in_if import i2a_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [IN_VALUE_W-1:0] value;
  logic                  is_signed;
  logic [1:0]            base_select;
  logic [FLAGS_W-1:0]    format_flags;
  logic [PADIN_W-1:0]    pad_width;

  modport source (output valid, value, is_signed, base_select, format_flags, pad_width,
                  input ready);
  modport sink   (input valid, value, is_signed, base_select, format_flags, pad_width,
                  output ready);
endinterface

// Output word: one character of the field
interface i2a_out_if import i2a_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last_char;
  logic [CNT_W-1:0]  char_count;

  modport source (output valid, char_out, last_char, char_count, input ready);
  modport sink   (input valid, char_out, last_char, char_count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/i2a_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module i2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/integer_to_ascii_formatter_top.sv
// Top level of the integer to ASCII formatter: sequencer, shared shift unit, char buffer.
// Depends on i2a_pkg, i2a_if, i2a_ram and integer_to_ascii_formatter_top_macros.svh.
//
//   channel | dir | words                           | handshake
//   item    | in  | value, sign, base, flags, width | valid/ready
//   text    | out | char_out, last_char, char_count | valid/ready
//
// Steps per word: accept, shift-add-3 conversion (decimal only), digit count,
// left pad, digit writes, zero pad, prefix, sign and fill pad, then the chars
// go out, one per taken transfer.
// The digit shifter is shared and the char buffer takes one write per cycle.
// Reset (rst, synchronous) returns the sequencer to idle; nothing is cleared.
// The input is not ready until the last char has been taken; text stalls hold.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_formatter_top_macros.svh"

module integer_to_ascii_formatter_top import i2a_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  i2a_in_if.sink    item,
  i2a_out_if.source text
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CONV   = 12'b000000000010,
    S_COUNT  = 12'b000000000100,
    S_LJUST  = 12'b000000001000,
    S_DIGITS = 12'b000000010000,
    S_ZPAD   = 12'b000000100000,
    S_PFX    = 12'b000001000000,
    S_PZERO  = 12'b000010000000,
    S_SIGN   = 12'b000100000000,
    S_FILLB  = 12'b001000000000,
    S_RJUST  = 12'b010000000000,
    S_EMIT   = 12'b100000000000
  } state_t;

  state_t                   state, state_next;
  base_t                    base, base_next;
  logic [FLAGS_W-1:0]       flags, flags_next;
  logic                     neg, neg_next;
  logic                     mag_nz, mag_nz_next;
  logic signed [PAD_W-1:0]  padding, padding_next;
  logic [CNT_W-1:0]         numlen, numlen_next;
  logic [CNT_W-1:0]         fill_len, fill_len_next;
  logic [VALUE_BITS-1:0]    bin, bin_next;
  logic [DSRC_W-1:0]        dsrc, dsrc_next;
  logic [DSRC_W-1:0]        tmp, tmp_next;
  logic [CONV_W-1:0]        conv_cnt, conv_cnt_next;
  logic [ADDR_W-1:0]        pos, pos_next;

  // Operand conditioning at accept
  logic [VALUE_BITS-1:0]    raw;
  logic                     neg_in;
  logic [VALUE_BITS-1:0]    mag_in;

  // Shared digit shifter and fill compares
  logic [DSRC_W-1:0]        tmp_sh;
  logic [3:0]               digit;
  logic [DSRC_W-1:0]        bcd_adj;
  logic                     not_full;
  logic                     below_pad;
  logic signed [PAD_W:0]    lj_lim;
  logic                     below_lj;
  logic signed [PAD_W-1:0]  pad_adj;

  // Buffer port
  logic                     wen;
  logic [CHAR_W-1:0]        wdata;
  logic [CHAR_W-1:0]        rdata;

  assign raw    = item.value[VALUE_BITS-1:0];
  assign neg_in = item.is_signed && raw[VALUE_BITS-1];
  assign mag_in = neg_in ? (VALUE_BITS'(0) - raw) : raw;

  // One digit step: shift width and digit mask follow the radix
  always_comb begin
    case (base)
      BASE_BIN: begin
        tmp_sh = tmp >> 1;
        digit  = tmp[3:0] & 4'h1;
      end
      BASE_OCT: begin
        tmp_sh = tmp >> 3;
        digit  = tmp[3:0] & 4'h7;
      end
      default: begin
        tmp_sh = tmp >> 4;
        digit  = tmp[3:0];
      end
    endcase
  end

  // Add-3 correction of every BCD digit ahead of the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (dsrc[i*4 +: 4] >= 4'd5) ? (dsrc[i*4 +: 4] + 4'd3)
                                                    : dsrc[i*4 +: 4];
    end
  end

  assign not_full  = fill_len < CNT_W'(FILL_LIMIT);
  assign below_pad = $signed({1'b0, fill_len}) < padding;
  assign lj_lim    = $signed({padding[PAD_W-1], padding}) - $signed({2'b00, numlen});
  assign below_lj  = $signed({2'b00, fill_len}) < lj_lim;

  // Alternate form adjusts the pad once the digit count is known
  always_comb begin
    pad_adj = padding;
    if (flags[FLAG_ALT]) begin
      if (base inside {BASE_BIN, BASE_HEX}) begin
        pad_adj = padding - PAD_W'(2);
      end else if (base == BASE_OCT && mag_nz && (padding < $signed({1'b0, numlen}))) begin
        pad_adj = padding + PAD_W'(1);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    base_next     = base;
    flags_next    = flags;
    neg_next      = neg;
    mag_nz_next   = mag_nz;
    padding_next  = padding;
    numlen_next   = numlen;
    bin_next      = bin;
    dsrc_next     = dsrc;
    tmp_next      = tmp;
    conv_cnt_next = conv_cnt;
    pos_next      = pos;
    wen           = 1'b0;
    wdata         = CH_SPACE;

    case (state)
      S_IDLE: begin
        if (item.valid) begin
          base_next     = base_t'(item.base_select);
          flags_next    = item.format_flags;
          neg_next      = neg_in;
          mag_nz_next   = mag_in != '0;
          padding_next  = $signed({2'b00, item.pad_width});
          numlen_next   = CNT_W'(1);
          bin_next      = mag_in;
          conv_cnt_next = '0;
          if (base_t'(item.base_select) == BASE_DEC) begin
            dsrc_next  = '0;
            state_next = S_CONV;
          end else begin
            dsrc_next  = DSRC_W'(mag_in);
            tmp_next   = DSRC_W'(mag_in);
            state_next = S_COUNT;
          end
        end
      end
      S_CONV: begin
        dsrc_next     = {bcd_adj[DSRC_W-2:0], bin[VALUE_BITS-1]};
        bin_next      = bin << 1;
        conv_cnt_next = conv_cnt + CONV_W'(1);
        if (conv_cnt == CONV_W'(VALUE_BITS - 1)) begin
          tmp_next   = {bcd_adj[DSRC_W-2:0], bin[VALUE_BITS-1]};
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        if (tmp_sh != '0) begin
          numlen_next = numlen + CNT_W'(1);
          tmp_next    = tmp_sh;
        end else begin
          padding_next = pad_adj;
          tmp_next     = dsrc;
          state_next   = S_LJUST;
        end
      end
      S_LJUST: begin
        if (flags[FLAG_LEFT] && !flags[FLAG_PREC] && not_full && below_lj) begin
          wen = 1'b1;
        end else begin
          state_next = S_DIGITS;
        end
      end
      S_DIGITS: begin
        wen      = not_full;
        wdata    = digit_char(digit);
        tmp_next = tmp_sh;
        if (tmp_sh == '0) begin
          state_next = S_ZPAD;
        end
      end
      S_ZPAD: begin
        wdata = CH_ZERO;
        if (flags[FLAG_ZERO] && not_full && below_pad) begin
          wen = 1'b1;
        end else begin
          state_next = S_PFX;
        end
      end
      S_PFX: begin
        wen        = flags[FLAG_ALT] && mag_nz && not_full &&
                     (base inside {BASE_HEX, BASE_BIN});
        wdata      = (base == BASE_HEX) ? CH_X : CH_B;
        state_next = S_PZERO;
      end
      S_PZERO: begin
        wen        = flags[FLAG_ALT] && mag_nz && not_full;
        wdata      = CH_ZERO;
        state_next = S_SIGN;
      end
      S_SIGN: begin
        wen        = (neg || flags[FLAG_PLUS]) && not_full;
        wdata      = neg ? CH_MINUS : CH_PLUS;
        state_next = S_FILLB;
      end
      S_FILLB: begin
        wdata = flags[FLAG_SPC] ? CH_SPACE : CH_ZERO;
        if ((flags[FLAG_SPC] || flags[FLAG_PREC]) && not_full && below_pad) begin
          wen = 1'b1;
        end else begin
          state_next = S_RJUST;
        end
      end
      S_RJUST: begin
        if (!flags[FLAG_LEFT] && !flags[FLAG_ZERO] && padding != '0 &&
            not_full && below_pad) begin
          wen = 1'b1;
        end else begin
          pos_next   = ADDR_W'(fill_len - CNT_W'(1));
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (text.ready) begin
          if (pos == '0) begin
            state_next = S_IDLE;
          end else begin
            pos_next = pos - ADDR_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Char count: cleared at accept, bumped on each stored char
  always_comb begin
    fill_len_next = fill_len;
    if (state == S_IDLE && item.valid) begin
      fill_len_next = '0;
    end else if (wen) begin
      fill_len_next = fill_len + CNT_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    base     <= base_next;
    flags    <= flags_next;
    neg      <= neg_next;
    mag_nz   <= mag_nz_next;
    padding  <= padding_next;
    numlen   <= numlen_next;
    fill_len <= fill_len_next;
    bin      <= bin_next;
    dsrc     <= dsrc_next;
    tmp      <= tmp_next;
    conv_cnt <= conv_cnt_next;
    pos      <= pos_next;
  end

  // Char buffer, filled right to left, read back at the next position
  i2a_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (FILL_LIMIT)
  ) u_buf (
    .clk   (clk),
    .we    (wen),
    .waddr (fill_len[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (pos_next),
    .rdata (rdata)
  );

  // Channel outputs
  assign item.ready      = (state == S_IDLE);
  assign text.valid      = (state == S_EMIT);
  assign text.char_out   = rdata;
  assign text.last_char  = (pos == '0);
  assign text.char_count = fill_len;

  // Checks
  `I2A_ASSERT_IMP(a_no_overlap, clk, rst, text.valid, !item.ready,
                  "input ready while a field is still going out")
  `I2A_ASSERT_NXT(a_field_cont, clk, rst, text.valid && text.ready && !text.last_char,
                  text.valid, "field broke off before its last char")
  `I2A_ASSERT_NXT(a_field_end, clk, rst, text.valid && text.ready && text.last_char,
                  item.ready, "not ready for a new word after the last char")
  `I2A_ASSERT_IMP(a_count_range, clk, rst, text.valid,
                  text.char_count != '0 && text.char_count <= CNT_W'(FILL_LIMIT),
                  "char count out of range")

endmodule

`default_nettype wire
